// ===== hdl/owrs_pkg.sv =====
// Types and constants shared by the 1-Wire ROM search engine.
// Standalone package; used by onewire_rom_search_engine.
package owrs_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int POS_W       = 6;
    localparam int FILL_W      = 7;

    typedef enum logic [1:0] {
        FUNC_NEW  = 2'd0,
        FUNC_PASS = 2'd1,
        FUNC_BIT  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NO_PRESENCE = 2'd1,
        STATUS_BOTH_ONE    = 2'd2,
        STATUS_SEQUENCE    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TOP,
        ST_CI,
        ST_BITEND,
        ST_POP_CHK,
        ST_POP_RD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        func_t func;
        logic  presence;
        logic  bit_a;
        logic  bit_b;
    } req_t;

    typedef struct packed {
        logic        write_valid;
        logic        write_bit;
        logic        address_valid;
        logic [63:0] rom_address;
        logic        search_done;
        logic [7:0]  device_count;
        status_t     status;
    } rsp_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             choice;
    } stack_entry_t;

endpackage

// ===== hdl/onewire_rom_search_engine.sv =====
// 1-Wire ROM search engine: sequencer, branch stack memory and address shifter; uses owrs_pkg.
// Steps: a new-search or pass item runs EXEC then FINISH; a bit pair in a pass runs EXEC,
// BITEND and FINISH; a conflict with a non-empty stack adds a top lookup (TOP) and may add
// a replay of an older branch (CI), and the last bit of a pass adds a pop check plus a pop read per popped branch.
// One item at a time: req_stall stays high until the sequencer is idle again; result stalls hold FINISH.
// Reset: async active low; sequencer idle, no search active; the stack memory is not cleared.
module onewire_rom_search_engine #(
    parameter int ROM_BITS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  owrs_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output owrs_pkg::rsp_t rsp
);
    import owrs_pkg::*;

    localparam logic [FILL_W-1:0] ROM_BITS_L = FILL_W'(ROM_BITS);
    localparam logic [FILL_W-1:0] DEPTH_L    = FILL_W'(STACK_DEPTH);
    localparam logic [FILL_W-1:0] CI_MAX     = {FILL_W{1'b1}};

    // sequencer
    state_t state_reg, state_next;
    req_t   item_reg;

    // search state
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] ci_reg, ci_next;
    logic [FILL_W-1:0] bitpos_reg, bitpos_next;
    logic [63:0]       shift_reg, shift_next;
    logic [7:0]        dev_reg, dev_next;
    logic              in_pass_reg, in_pass_next;
    logic              active_reg, active_next;

    // per-item result bits
    logic    dir_reg, dir_next;
    logic    wv_reg, wv_next;
    logic    av_reg, av_next;
    status_t status_reg, status_next;

    // output register
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;

    // branch stack: one write port, one registered read port
    stack_entry_t       stack_mem [STACK_DEPTH];
    stack_entry_t       rd_data;
    logic [POS_W-1:0]   rd_addr;
    logic               mem_we;
    logic [POS_W-1:0]   mem_waddr;
    stack_entry_t       mem_wdata;

    logic [POS_W-1:0]  pos;
    logic [FILL_W-1:0] ci_inc;
    logic [FILL_W-1:0] bitpos_inc;
    logic              conflict;
    logic              out_free;

    assign pos        = bitpos_reg[POS_W-1:0];
    assign ci_inc     = (ci_reg < CI_MAX) ? ci_reg + FILL_W'(1) : ci_reg;
    assign bitpos_inc = bitpos_reg + FILL_W'(1);
    assign conflict   = (item_reg.bit_a == item_reg.bit_b);
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= stack_mem[rd_addr];
    end

    // read address: stack top, except in the top lookup, which reads the replay entry at ci_reg
    always_comb
    begin
        if (state_reg == ST_TOP)
        begin
            rd_addr = ci_reg[POS_W-1:0];
        end
        else
        begin
            rd_addr = fill_reg[POS_W-1:0] - POS_W'(1);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FINISH;
                if (item_reg.func == FUNC_BIT && in_pass_reg
                    && !(item_reg.bit_a && item_reg.bit_b))
                begin
                    if (conflict && fill_reg != '0)
                    begin
                        state_next = ST_TOP;
                    end
                    else
                    begin
                        state_next = ST_BITEND;
                    end
                end
            end
            ST_TOP:
            begin
                if (pos < rd_data.pos && ci_reg < fill_reg)
                begin
                    state_next = ST_CI;
                end
                else
                begin
                    state_next = ST_BITEND;
                end
            end
            ST_CI:
            begin
                state_next = ST_BITEND;
            end
            ST_BITEND:
            begin
                state_next = (bitpos_inc >= ROM_BITS_L) ? ST_POP_CHK : ST_FINISH;
            end
            ST_POP_CHK:
            begin
                state_next = (fill_reg != '0 && rd_data.choice) ? ST_POP_RD : ST_FINISH;
            end
            ST_POP_RD:
            begin
                state_next = ST_POP_CHK;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs of the sequencer
    always_comb
    begin
        fill_next      = fill_reg;
        ci_next        = ci_reg;
        bitpos_next    = bitpos_reg;
        shift_next     = shift_reg;
        dev_next       = dev_reg;
        in_pass_next   = in_pass_reg;
        active_next    = active_reg;
        dir_next       = dir_reg;
        wv_next        = wv_reg;
        av_next        = av_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = fill_reg[POS_W-1:0];
        mem_wdata      = '{pos: pos, choice: 1'b0};

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                wv_next     = 1'b0;
                av_next     = 1'b0;
                dir_next    = 1'b0;
                status_next = STATUS_OK;
            end
            ST_EXEC:
            begin
                case (item_reg.func)
                    FUNC_NEW:
                    begin
                        fill_next    = '0;
                        ci_next      = '0;
                        bitpos_next  = '0;
                        shift_next   = '0;
                        dev_next     = '0;
                        in_pass_next = 1'b0;
                        active_next  = 1'b1;
                    end
                    FUNC_PASS:
                    begin
                        if (!active_reg || in_pass_reg)
                        begin
                            status_next = STATUS_SEQUENCE;
                        end
                        else if (!item_reg.presence)
                        begin
                            active_next = 1'b0;
                            status_next = STATUS_NO_PRESENCE;
                        end
                        else
                        begin
                            in_pass_next = 1'b1;
                            bitpos_next  = '0;
                            ci_next      = '0;
                            shift_next   = '0;
                        end
                    end
                    FUNC_BIT:
                    begin
                        if (!in_pass_reg)
                        begin
                            status_next = STATUS_SEQUENCE;
                        end
                        else if (item_reg.bit_a && item_reg.bit_b)
                        begin
                            in_pass_next = 1'b0;
                            active_next  = 1'b0;
                            status_next  = STATUS_BOTH_ONE;
                        end
                        else
                        begin
                            wv_next = 1'b1;
                            if (!conflict)
                            begin
                                dir_next = item_reg.bit_a;
                            end
                            else if (fill_reg == '0)
                            begin
                                // first branch of an empty stack
                                mem_we    = 1'b1;
                                fill_next = fill_reg + FILL_W'(1);
                                ci_next   = ci_inc;
                                dir_next  = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        status_next = STATUS_SEQUENCE;
                    end
                endcase
            end
            ST_TOP:
            begin
                ci_next = ci_inc;
                if (pos > rd_data.pos)
                begin
                    // new branch, take 0; full stack drops the push
                    dir_next = 1'b0;
                    if (fill_reg < DEPTH_L)
                    begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
                else if (pos == rd_data.pos)
                begin
                    // flip the top branch to its 1 side
                    dir_next  = 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = fill_reg[POS_W-1:0] - POS_W'(1);
                    mem_wdata = '{pos: rd_data.pos, choice: 1'b1};
                end
                else
                begin
                    dir_next = 1'b0;
                end
            end
            ST_CI:
            begin
                dir_next = rd_data.choice;
            end
            ST_BITEND:
            begin
                if (dir_reg)
                begin
                    shift_next[pos] = 1'b1;
                end
                bitpos_next = bitpos_inc;
            end
            ST_POP_CHK:
            begin
                if (fill_reg != '0 && rd_data.choice)
                begin
                    fill_next = fill_reg - FILL_W'(1);
                end
                else
                begin
                    av_next      = 1'b1;
                    in_pass_next = 1'b0;
                    if (dev_reg != 8'hFF)
                    begin
                        dev_next = dev_reg + 8'd1;
                    end
                    if (fill_reg == '0)
                    begin
                        active_next = 1'b0;
                    end
                end
            end
            ST_POP_RD:
            begin
                // read of the new top issued through rd_addr
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_next.write_valid      = wv_reg;
                    rsp_next.write_bit        = wv_reg & dir_reg;
                    rsp_next.address_valid    = av_reg;
                    rsp_next.rom_address      = av_reg ? shift_reg : 64'd0;
                    rsp_next.search_done      = !active_reg;
                    rsp_next.device_count     = dev_reg;
                    rsp_next.status           = status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            ci_reg        <= '0;
            bitpos_reg    <= '0;
            shift_reg     <= '0;
            dev_reg       <= '0;
            in_pass_reg   <= 1'b0;
            active_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ci_reg        <= ci_next;
            bitpos_reg    <= bitpos_next;
            shift_reg     <= shift_next;
            dev_reg       <= dev_next;
            in_pass_reg   <= in_pass_next;
            active_reg    <= active_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_valid)
        begin
            item_reg <= req;
        end
        dir_reg    <= dir_next;
        wv_reg     <= wv_next;
        av_reg     <= av_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
